// ===== rtl/bdscbi_pkg.sv =====
// Package for the BeiDou code bias elevation interpolation unit.
// Holds field widths, band codes, the IGSO and MEO bias tables and the table lookup function.
// No dependencies; used by the lane, rounding and top-level modules and by the testbench.
package bdscbi_pkg;

   localparam int TABLE_POINTS = 17;
   localparam int CORR_W       = 11;
   localparam int ELEV_W       = 16;
   localparam int PRN_W        = 6;
   localparam int IDX_W        = 5;
   localparam int WEIGHT_W     = 11;
   localparam int NUM_W        = 23;

   localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(TABLE_POINTS - 1);
   localparam logic [PRN_W-1:0]  IGSO_FIRST = 6'd6;
   localparam logic [PRN_W-1:0]  IGSO_LAST  = 6'd10;
   localparam logic [PRN_W-1:0]  MEO_FIRST  = 6'd11;
   localparam logic [PRN_W-1:0]  MEO_LAST   = 6'd14;

   localparam logic [1:0] BAND_B1 = 2'd0;
   localparam logic [1:0] BAND_B2 = 2'd1;
   localparam logic [1:0] BAND_B3 = 2'd2;

   typedef struct packed {
      logic                in_tab;
      logic                use_meo;
      logic [IDX_W-1:0]    base;
      logic [IDX_W-1:0]    next;
      logic [WEIGHT_W-1:0] weight;
   } sel_type;

   localparam logic signed [CORR_W-1:0] IGSO_TAB [0:2][0:TABLE_POINTS-1] = '{
      '{-11'sd238, -11'sd540, -11'sd430, -11'sd274, -11'sd255, -11'sd265, -11'sd168,
        -11'sd137, -11'sd64, -11'sd19, 11'sd25, 11'sd130, 11'sd175, 11'sd238, 11'sd234,
        11'sd272, 11'sd302},
      '{-11'sd246, -11'sd421, -11'sd296, -11'sd272, -11'sd260, -11'sd227, -11'sd154,
        -11'sd115, -11'sd68, -11'sd41, 11'sd37, 11'sd79, 11'sd116, 11'sd167, 11'sd202,
        11'sd250, 11'sd259},
      '{-11'sd406, -11'sd211, -11'sd169, -11'sd157, -11'sd138, -11'sd253, -11'sd89,
        -11'sd118, -11'sd73, -11'sd10, -11'sd8, 11'sd49, 11'sd84, 11'sd127, 11'sd152,
        11'sd207, 11'sd155}
   };

   localparam logic signed [CORR_W-1:0] MEO_TAB [0:2][0:TABLE_POINTS-1] = '{
      '{-11'sd375, -11'sd405, -11'sd314, -11'sd220, -11'sd180, -11'sd144, -11'sd179,
        -11'sd91, 11'sd5, 11'sd81, 11'sd222, 11'sd322, 11'sd463, 11'sd631, 11'sd716,
        11'sd918, 11'sd955},
      '{-11'sd400, -11'sd238, -11'sd213, -11'sd228, -11'sd131, -11'sd113, -11'sd114,
        -11'sd65, 11'sd6, 11'sd68, 11'sd187, 11'sd224, 11'sd326, 11'sd440, 11'sd485,
        11'sd583, 11'sd628},
      '{-11'sd134, -11'sd174, -11'sd112, -11'sd131, -11'sd47, -11'sd52, -11'sd81,
        -11'sd30, 11'sd44, 11'sd48, 11'sd83, 11'sd133, 11'sd201, 11'sd287, 11'sd288,
        11'sd367, 11'sd393}
   };

   function automatic logic signed [CORR_W-1:0] tab_value(input logic             meo,
                                                          input logic [1:0]       band,
                                                          input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] k;
      logic [1:0]       b;
      k = (idx > LAST_INDEX) ? LAST_INDEX : idx;
      b = (band > BAND_B3) ? BAND_B3 : band;
      return meo ? MEO_TAB[b][k] : IGSO_TAB[b][k];
   endfunction

endpackage

// ===== rtl/bdscbi_lane.sv =====
// One band lane: table lookup and linear interpolation numerator in mm/1280.
// Depends on bdscbi_pkg.
module bdscbi_lane (
   input  logic [1:0]                       band,
   input  bdscbi_pkg::sel_type              sel,
   output logic signed [bdscbi_pkg::NUM_W-1:0] num
);

   logic signed [bdscbi_pkg::CORR_W-1:0] t0;
   logic signed [bdscbi_pkg::CORR_W-1:0] t1;
   logic signed [bdscbi_pkg::CORR_W:0]   diff;
   logic signed [23:0]                   prod;
   logic signed [23:0]                   scaled;
   logic signed [23:0]                   sum;

   assign t0     = bdscbi_pkg::tab_value(sel.use_meo, band, sel.base);
   assign t1     = bdscbi_pkg::tab_value(sel.use_meo, band, sel.next);
   assign diff   = 12'(t1) - 12'(t0);
   assign prod   = 24'(diff) * 24'($signed({1'b0, sel.weight}));
   assign scaled = (24'(t0) <<< 10) + (24'(t0) <<< 8);
   assign sum    = scaled + prod;
   assign num    = sel.in_tab ? sum[bdscbi_pkg::NUM_W-1:0] : '0;

endmodule

// ===== rtl/bdscbi_round.sv =====
// Rounds a numerator in mm/1280 to whole millimetres, ties away from zero.
// Depends on bdscbi_pkg.
module bdscbi_round (
   input  logic signed [bdscbi_pkg::NUM_W-1:0]  num,
   output logic signed [bdscbi_pkg::CORR_W-1:0] corr
);

   logic                               neg;
   logic [bdscbi_pkg::NUM_W-1:0]       neg_num;
   logic [21:0]                        mag;
   logic [21:0]                        biased;
   logic [12:0]                        quot256;
   logic [26:0]                        prod;
   logic [bdscbi_pkg::CORR_W-1:0]      res;

   assign neg     = num[bdscbi_pkg::NUM_W-1];
   assign neg_num = bdscbi_pkg::NUM_W'(-num);
   assign mag     = neg ? neg_num[21:0] : num[21:0];
   assign biased  = mag + 22'd640;
   assign quot256 = biased[20:8];
   assign prod    = 27'(quot256) * 27'd6554;
   assign res     = prod[25:15];
   assign corr    = neg ? bdscbi_pkg::CORR_W'(-res) : res;

endmodule

// ===== rtl/bds_code_bias_elevation_interp_unit.sv =====
// Top level of the BeiDou code bias elevation interpolation unit.
// Depends on bdscbi_pkg, bdscbi_lane and bdscbi_round.
//
// Takes one word per cycle: PRN and elevation (1/256 degree) with the BeiDou flag, and returns
// one word with the B1, B2 and B3 code bias corrections in millimetres and a valid flag.
// The unit is a three-register pipeline (input, interpolation numerator, result), and a new
// word is taken every cycle while the pipeline does not stall; the table-weight multiply and
// the rounding multiply each fill one stage. Stages only stall when the result register holds
// a word that is not taken, and empty stages close up.
module bds_code_bias_elevation_interp_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [5:0] sat_prn, [21:6] elevation, [23:22] zero
   input  logic        req_tuser,  // [0] system_is_beidou
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [10:0] corr_b1, [21:11] corr_b2, [32:22] corr_b3, [39:33] 0
   output logic        rsp_tuser   // [0] valid_res
);

   localparam int NW = bdscbi_pkg::NUM_W;
   localparam int CW = bdscbi_pkg::CORR_W;

   logic                             in_valid_ff, in_valid_in;
   logic                             bds_ff;
   logic [bdscbi_pkg::PRN_W-1:0]     prn_ff;
   logic [bdscbi_pkg::ELEV_W-1:0]    elev_ff;
   logic                             mid_valid_ff, mid_valid_in;
   logic                             mid_ok_ff;
   logic signed [NW-1:0]             num_ff [0:2];
   logic signed [NW-1:0]             num_in [0:2];
   logic                             out_valid_ff, out_valid_in;
   logic                             out_ok_ff;
   logic signed [CW-1:0]             corr_ff [0:2];
   logic signed [CW-1:0]             corr_in [0:2];

   logic                             adv_out, adv_mid, adv_in;
   logic                             ok;
   logic                             is_igso, is_meo;
   logic [6:0]                       q8;
   logic [14:0]                      qmul;
   logic [bdscbi_pkg::IDX_W-1:0]     idx;
   logic [6:0]                       five_idx;
   logic [2:0]                       rem;
   bdscbi_pkg::sel_type              sel;

   assign adv_out    = ~out_valid_ff | rsp_tready;
   assign adv_mid    = ~mid_valid_ff | adv_out;
   assign adv_in     = ~in_valid_ff | adv_mid;
   assign req_tready = adv_in;

   assign in_valid_in  = adv_in ? req_tvalid : in_valid_ff;
   assign mid_valid_in = adv_mid ? in_valid_ff : mid_valid_ff;
   assign out_valid_in = adv_out ? mid_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         bds_ff  <= req_tuser;
         prn_ff  <= req_tdata[5:0];
         elev_ff <= req_tdata[21:6];
      end
   end

   // index decode: idx = elevation / 1280, weight = elevation mod 1280 (zero for idx 0 and from the last point)
   assign ok       = bds_ff & ~elev_ff[15] & (|elev_ff[14:0]);
   assign is_igso  = (prn_ff >= bdscbi_pkg::IGSO_FIRST) && (prn_ff <= bdscbi_pkg::IGSO_LAST);
   assign is_meo   = (prn_ff >= bdscbi_pkg::MEO_FIRST) && (prn_ff <= bdscbi_pkg::MEO_LAST);
   assign q8       = elev_ff[14:8];
   assign qmul     = 15'(q8) * 15'd205;
   assign idx      = qmul[14:10];
   assign five_idx = 7'(idx) * 7'd5;
   assign rem      = 3'(q8 - five_idx);

   always_comb begin
      sel.in_tab  = ok & (is_igso | is_meo);
      sel.use_meo = is_meo;
      if (idx >= bdscbi_pkg::LAST_INDEX) begin
         sel.base   = bdscbi_pkg::LAST_INDEX;
         sel.weight = '0;
      end else begin
         sel.base   = idx;
         sel.weight = (idx == '0) ? '0 : {rem, elev_ff[7:0]};
      end
      sel.next = (sel.base == bdscbi_pkg::LAST_INDEX) ? bdscbi_pkg::LAST_INDEX
                                                      : sel.base + 1'b1;
   end

   bdscbi_lane u_lane_b1 (.band(bdscbi_pkg::BAND_B1), .sel(sel), .num(num_in[0]));
   bdscbi_lane u_lane_b2 (.band(bdscbi_pkg::BAND_B2), .sel(sel), .num(num_in[1]));
   bdscbi_lane u_lane_b3 (.band(bdscbi_pkg::BAND_B3), .sel(sel), .num(num_in[2]));

   always_ff @(posedge clock) begin
      if (adv_mid) begin
         mid_ok_ff <= ok;
         num_ff[0] <= num_in[0];
         num_ff[1] <= num_in[1];
         num_ff[2] <= num_in[2];
      end
   end

   bdscbi_round u_round_b1 (.num(num_ff[0]), .corr(corr_in[0]));
   bdscbi_round u_round_b2 (.num(num_ff[1]), .corr(corr_in[1]));
   bdscbi_round u_round_b3 (.num(num_ff[2]), .corr(corr_in[2]));

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_ok_ff  <= mid_ok_ff;
         corr_ff[0] <= corr_in[0];
         corr_ff[1] <= corr_in[1];
         corr_ff[2] <= corr_in[2];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {7'd0, corr_ff[2], corr_ff[1], corr_ff[0]};

endmodule

// ===== rtl/bdscbi_checker.sv =====
// Port-level checks for the BeiDou code bias elevation interpolation unit, with its bind.
// Depends on bds_code_bias_elevation_interp_unit.
module bdscbi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("invalid word carries nonzero corrections");

   a_b1_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[10:0]) >= -11'sd1000) &&
                     ($signed(rsp_tdata[10:0]) <= 11'sd1000))
      else $error("corr_b1 out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word present after reset");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready && req_tvalid && !reset |-> ##1 (req_tready || !rsp_tready || !req_tvalid))
      else $error("input stalled although output drains");

endmodule

bind bds_code_bias_elevation_interp_unit bdscbi_checker u_bdscbi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/testbench.sv =====
// Testbench for bds_code_bias_elevation_interp_unit: directed and random observations go
// through the request stream, and each result word is checked against its own bias predictor.
// Depends on bdscbi_pkg and the RTL of the unit.
module testbench;

   localparam int STEP_UNITS  = 1280;
   localparam int HALF_STEP   = 640;
   localparam int LAST_POINT  = bdscbi_pkg::TABLE_POINTS - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 12;
   localparam int PRINT_LIMIT = 60;

   localparam int IGSO_MM [0:2][0:16] = '{
      '{-238, -540, -430, -274, -255, -265, -168, -137, -64, -19, 25, 130, 175, 238, 234,
        272, 302},
      '{-246, -421, -296, -272, -260, -227, -154, -115, -68, -41, 37, 79, 116, 167, 202,
        250, 259},
      '{-406, -211, -169, -157, -138, -253, -89, -118, -73, -10, -8, 49, 84, 127, 152,
        207, 155}
   };

   localparam int MEO_MM [0:2][0:16] = '{
      '{-375, -405, -314, -220, -180, -144, -179, -91, 5, 81, 222, 322, 463, 631, 716,
        918, 955},
      '{-400, -238, -213, -228, -131, -113, -114, -65, 6, 68, 187, 224, 326, 440, 485,
        583, 628},
      '{-134, -174, -112, -131, -47, -52, -81, -30, 44, 48, 83, 133, 201, 287, 288,
        367, 393}
   };

   typedef struct packed {
      logic                                bds;
      logic [bdscbi_pkg::PRN_W-1:0]        prn;
      logic signed [bdscbi_pkg::ELEV_W-1:0] elev;
   } sat_obs_type;

   typedef struct packed {
      logic                                valid;
      logic signed [bdscbi_pkg::CORR_W-1:0] b1;
      logic signed [bdscbi_pkg::CORR_W-1:0] b2;
      logic signed [bdscbi_pkg::CORR_W-1:0] b3;
   } code_bias_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;  // [5:0] sat_prn, [21:6] elevation, [23:22] zero
   logic        req_tuser;  // [0] system_is_beidou
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;  // [10:0] corr_b1, [21:11] corr_b2, [32:22] corr_b3, [39:33] zero
   logic        rsp_tuser;  // [0] valid_res

   sat_obs_type   obs_pending [$];
   code_bias_type bias_due [$];
   int         obs_total;
   int         obs_taken;
   int         mismatch_count;
   int         cycle_count;
   bit         req_taken;
   int         burst_left;
   int         gap_left;
   int         ready_mode_left;
   logic [31:0] ready_pat;

   bds_code_bias_elevation_interp_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic int table_mm(bit meo, int band, int point);
      return meo ? MEO_MM[band][point] : IGSO_MM[band][point];
   endfunction

   function automatic int round_step(int n);
      if (n >= 0)
         return (n + HALF_STEP) / STEP_UNITS;
      return -((-n + HALF_STEP) / STEP_UNITS);
   endfunction

   function automatic code_bias_type code_bias_of(sat_obs_type s);
      code_bias_type b;
      int         e;
      int         idx;
      int         r;
      int         v [0:2];
      bit         meo;
      b = '0;
      e = s.elev;
      if (!s.bds || e <= 0)
         return b;
      b.valid = 1'b1;
      if (s.prn >= bdscbi_pkg::IGSO_FIRST && s.prn <= bdscbi_pkg::IGSO_LAST)
         meo = 1'b0;
      else if (s.prn >= bdscbi_pkg::MEO_FIRST && s.prn <= bdscbi_pkg::MEO_LAST)
         meo = 1'b1;
      else
         return b;
      idx = e / STEP_UNITS;
      r   = e % STEP_UNITS;
      for (int k = 0; k < 3; k++) begin
         if (idx <= 0)
            v[k] = table_mm(meo, k, 0);
         else if (idx >= LAST_POINT)
            v[k] = table_mm(meo, k, LAST_POINT);
         else
            v[k] = round_step(table_mm(meo, k, idx) * (STEP_UNITS - r)
                              + table_mm(meo, k, idx + 1) * r);
      end
      b.b1 = bdscbi_pkg::CORR_W'(v[bdscbi_pkg::BAND_B1]);
      b.b2 = bdscbi_pkg::CORR_W'(v[bdscbi_pkg::BAND_B2]);
      b.b3 = bdscbi_pkg::CORR_W'(v[bdscbi_pkg::BAND_B3]);
      return b;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_obs(logic bds, logic [bdscbi_pkg::PRN_W-1:0] prn,
                            logic signed [bdscbi_pkg::ELEV_W-1:0] elev);
      sat_obs_type s;
      s.bds  = bds;
      s.prn  = prn;
      s.elev = elev;
      obs_pending.push_back(s);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // request side: count accepted words and predict; result side: compare
   always @(posedge clock) begin
      sat_obs_type   s;
      code_bias_type got;
      code_bias_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            s.bds  = req_tuser;
            s.prn  = req_tdata[5:0];
            s.elev = req_tdata[21:6];
            bias_due.push_back(code_bias_of(s));
            obs_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.valid = rsp_tuser;
            got.b1    = rsp_tdata[10:0];
            got.b2    = rsp_tdata[21:11];
            got.b3    = rsp_tdata[32:22];
            if (bias_due.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = bias_due.pop_front();
               if (got.valid !== want.valid)
                  report_mismatch($sformatf("valid_res got %b want %b", got.valid, want.valid));
               if (got.b1 !== want.b1)
                  report_mismatch($sformatf("corr_b1 got %0d want %0d", got.b1, want.b1));
               if (got.b2 !== want.b2)
                  report_mismatch($sformatf("corr_b2 got %0d want %0d", got.b2, want.b2));
               if (got.b3 !== want.b3)
                  report_mismatch($sformatf("corr_b3 got %0d want %0d", got.b3, want.b3));
            end
         end
      end
   end

   // driver: bursts with gaps on req, rotating stall pattern on rsp
   always @(negedge clock) begin
      sat_obs_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (gap_left > 0 || obs_pending.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               s = obs_pending.pop_front();
               req_tdata  <= {2'b00, s.elev, s.prn};
               req_tuser  <= s.bds;
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         if (ready_mode_left == 0) begin
            ready_mode_left = $urandom_range(32, 200);
            case ($urandom_range(0, 3))
               0: ready_pat = '1;
               1: ready_pat = $urandom;
               2: ready_pat = $urandom & $urandom & $urandom;
               default: ready_pat = ~($urandom & $urandom);
            endcase
            if (ready_pat == '0)
               ready_pat = 32'd1;
         end else begin
            ready_mode_left--;
         end
         rsp_tready <= ready_pat[0];
         ready_pat = {ready_pat[0], ready_pat[31:1]};
      end
   end

   initial begin
      int sel;
      int k;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      rsp_tready      = 1'b0;
      obs_taken       = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      req_taken       = 1'b0;
      burst_left      = 1;
      gap_left        = 0;
      ready_mode_left = 0;
      ready_pat       = '1;

      queue_obs(1'b0, 6'd6, 16'sd6400);
      queue_obs(1'b0, 6'd63, -16'sd1);
      queue_obs(1'b1, 6'd6, 16'sd0);
      queue_obs(1'b1, 6'd11, -16'sd1);
      queue_obs(1'b1, 6'd14, 16'sh8000);
      queue_obs(1'b1, 6'd6, 16'sd32767);
      queue_obs(1'b1, 6'd14, 16'sd23040);
      queue_obs(1'b1, 6'd10, 16'sd1);
      queue_obs(1'b1, 6'd11, 16'sd1279);
      queue_obs(1'b1, 6'd7, 16'sd1280);
      queue_obs(1'b1, 6'd12, 16'sd1281);
      queue_obs(1'b1, 6'd8, 16'sd20479);
      queue_obs(1'b1, 6'd13, 16'sd20480);
      queue_obs(1'b1, 6'd6, 16'sd1920);
      queue_obs(1'b1, 6'd6, 16'sd14720);
      queue_obs(1'b1, 6'd5, 16'sd6400);
      queue_obs(1'b1, 6'd15, 16'sd6400);
      queue_obs(1'b1, 6'd0, 16'sd12000);
      queue_obs(1'b1, 6'd63, 16'sd32767);
      queue_obs(1'b1, 6'd10, 16'sd11000);
      queue_obs(1'b1, 6'd11, 16'sd11000);
      queue_obs(1'b1, 6'd14, 16'sd3000);
      queue_obs(1'b1, 6'd9, 16'sd23040);

      for (int i = 0; i < 950; i++) begin
         sel = $urandom_range(0, 9);
         if (sel <= 5) begin
            queue_obs(1'b1,
                      bdscbi_pkg::PRN_W'($urandom_range(bdscbi_pkg::IGSO_FIRST,
                                                        bdscbi_pkg::MEO_LAST)),
                      bdscbi_pkg::ELEV_W'($urandom_range(1, 23040)));
         end else if (sel == 6) begin
            k = $urandom_range(0, bdscbi_pkg::TABLE_POINTS) * STEP_UNITS
                + $urandom_range(0, 2) - 1;
            queue_obs(1'b1,
                      bdscbi_pkg::PRN_W'($urandom_range(bdscbi_pkg::IGSO_FIRST,
                                                        bdscbi_pkg::MEO_LAST)),
                      bdscbi_pkg::ELEV_W'(k));
         end else if (sel == 7) begin
            queue_obs(1'($urandom_range(0, 1)), bdscbi_pkg::PRN_W'($urandom_range(0, 15)),
                      bdscbi_pkg::ELEV_W'($urandom));
         end else begin
            queue_obs(1'($urandom_range(0, 1)), bdscbi_pkg::PRN_W'($urandom),
                      bdscbi_pkg::ELEV_W'($urandom));
         end
      end
      obs_total = obs_pending.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (obs_taken < obs_total || bias_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatch_count == 0 && bias_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
